// File: hw/rtl/joystick_axis_filter_classifier_unit_defines.svh
// assertion macros used by the joystick axis filter top level
`ifndef JOYSTICK_AXIS_FILTER_CLASSIFIER_UNIT_DEFINES_SVH
`define JOYSTICK_AXIS_FILTER_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define JAFC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define JAFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/jafc_pkg.sv
// shared types and constants of the joystick axis filter and classifier
`timescale 1ns / 1ps

package jafc_pkg;

    // field widths
    localparam int AXIS_W      = 2;
    localparam int SAMPLE_W    = 8;
    localparam int LEVEL_W     = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_THR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MID_THR = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_THR = 2'd2;

    // threshold reset values
    localparam logic [CFG_DATA_W-1:0] MAX_THR_RST = 8'd96;
    localparam logic [CFG_DATA_W-1:0] MID_THR_RST = 8'd64;
    localparam logic [CFG_DATA_W-1:0] MIN_THR_RST = 8'd32;

    // mid-scale split points
    localparam logic [SAMPLE_W-1:0] SIDE_LIMIT = 8'd127;
    localparam logic [SAMPLE_W-1:0] MID_SCALE  = 8'd128;

    // level codes
    localparam logic [LEVEL_W-1:0] LVL_NONE   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_SMALL  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_MEDIUM = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_FULL   = 2'd3;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] max_thr;
        logic [CFG_DATA_W-1:0] mid_thr;
        logic [CFG_DATA_W-1:0] min_thr;
    } thr_t;

    // finished filter result handed to the output stage
    typedef struct packed {
        logic                valid;
        logic                bad_axis;
        logic [AXIS_W-1:0]   axis;
        logic [SAMPLE_W-1:0] filtered;
    } res_t;

endpackage

// File: hw/rtl/jafc_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module jafc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/jafc_out.sv
// side split, threshold quantizer and output register of the result stream
`timescale 1ns / 1ps

module jafc_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  jafc_pkg::res_t                      res,
    input  jafc_pkg::thr_t                      thr,
    output logic                                out_rdy,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // axis_out[1:0], filtered[9:2], high_side[10], level[12:11], zeros[15:13]
    output logic [jafc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    import jafc_pkg::*;

    logic                  high_side;
    logic [SAMPLE_W-1:0]   defl;
    logic [LEVEL_W-1:0]    level;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // split about mid-scale
    always_comb begin
        high_side = (res.filtered > SIDE_LIMIT);
        if (high_side) begin
            defl = res.filtered - MID_SCALE;
        end else begin
            defl = SIDE_LIMIT - res.filtered;
        end
    end

    // quantize, first threshold met wins
    always_comb begin
        if (defl >= thr.max_thr) begin
            level = LVL_FULL;
        end else if (defl >= thr.mid_thr) begin
            level = LVL_MEDIUM;
        end else if (defl >= thr.min_thr) begin
            level = LVL_SMALL;
        end else begin
            level = LVL_NONE;
        end
    end

    assign out_rdy = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res.valid && out_rdy) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload, all zeros but the axis field for an axis outside the store
    always_ff @(posedge aclk) begin
        if (res.valid && out_rdy) begin
            if (res.bad_axis) begin
                m_tdata_reg <= {{(OUT_TDATA_W - AXIS_W){1'b0}}, res.axis};
            end else begin
                m_tdata_reg <= {3'b000, level, high_side, res.filtered, res.axis};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hw/rtl/joystick_axis_filter_classifier_unit.sv
// top level: per-axis sample ring in ram, tap sequencer and shift-add filter
`timescale 1ns / 1ps
`include "joystick_axis_filter_classifier_unit_defines.svh"

// channel   dir  fields (lowest bit up)                       handshake
// s_        in   axis[1:0], sample[9:2]                        s_tvalid / s_tready
// m_        out  axis_out[1:0], filtered[9:2], high_side[10],  m_tvalid / m_tready
//                level[12:11]
// cfg_      in   cfg_addr selects threshold, cfg_wdata         cfg_we, no wait
//
// an item is written into its axis ring, then read back through the single ram read port, which
// walks the axis ring one entry a cycle, and is pushed from the out state after a drain state.
// an axis outside the store skips the ring and goes from idle straight to the out state.
// reset (synchronous, aresetn low) clears valid bits, pointers and thresholds;
// no clearing pass is needed.
// a stalled output holds one result while the next item is already in work.

module joystick_axis_filter_classifier_unit #(
    parameter int AXES = 4,
    parameter int TAPS = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // axis[1:0], sample[9:2], zeros[15:10]
    input  logic [jafc_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // axis_out[1:0], filtered[9:2], high_side[10], level[12:11], zeros[15:13]
    output logic [jafc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [jafc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [jafc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import jafc_pkg::*;

    localparam int DEPTH = AXES * TAPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AXW   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int PW    = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AXIS_W-1:0]   axis_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                bad_reg;
    logic [AW-1:0]       base_reg;
    logic [PW-1:0]       tap_reg, tap_next;
    logic [PW-1:0]       wp_reg [AXES];
    logic [DEPTH-1:0]    vld_reg;
    logic                rd_pend_reg;
    logic                rd_vld_reg;
    logic [SAMPLE_W-1:0] acc_reg, acc_next;
    thr_t                thr_reg;

    logic [AXIS_W-1:0]   s_axis;
    logic [SAMPLE_W-1:0] s_sample;
    logic                s_xfer;
    logic                s_bad;
    logic [AXW-1:0]      ax_idx;
    logic [PW-1:0]       wp_cur;
    logic [PW-1:0]       wp_inc;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                out_rdy;
    res_t                res;

    // input unpacking
    assign s_axis   = s_tdata[AXIS_W-1:0];
    assign s_sample = s_tdata[AXIS_W +: SAMPLE_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign s_bad    = (32'(s_axis) >= AXES);

    // ring pointer of the current axis
    assign ax_idx    = AXW'(axis_reg);
    assign wp_cur    = wp_reg[ax_idx];
    assign wp_inc    = (32'(wp_cur) >= TAPS - 1) ? '0 : PW'(32'(wp_cur) + 1);
    assign ram_we    = (state_reg == S_WRITE);
    assign ram_waddr = base_reg + AW'(wp_cur);
    assign ram_raddr = base_reg + AW'(tap_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_bad ? S_OUT : S_WRITE;
                end
            end
            S_WRITE: begin
                state_next = S_READ;
                tap_next   = '0;
            end
            S_READ: begin
                if (32'(tap_reg) >= TAPS - 1) begin
                    state_next = S_DRAIN;
                end else begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_rdy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shift-add accumulation on returned read data
    always_comb begin
        acc_next = acc_reg;
        if (s_xfer) begin
            acc_next = '0;
        end else if (rd_pend_reg) begin
            acc_next = {1'b0, acc_reg[SAMPLE_W-1:1]}
                     + (rd_vld_reg ? {1'b0, ram_rdata[SAMPLE_W-1:1]} : '0);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tap_reg     <= '0;
            rd_pend_reg <= 1'b0;
            vld_reg     <= '0;
            for (int i = 0; i < AXES; i++) begin
                wp_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            rd_pend_reg <= (state_reg == S_READ);
            if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
                wp_reg[ax_idx]     <= wp_inc;
            end
        end
    end

    // item payload and accumulator
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            axis_reg   <= s_axis;
            sample_reg <= s_sample;
            bad_reg    <= s_bad;
            base_reg   <= AW'(32'(s_axis) * TAPS);
        end
        rd_vld_reg <= vld_reg[ram_raddr];
        acc_reg    <= acc_next;
    end

    // threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.max_thr <= MAX_THR_RST;
            thr_reg.mid_thr <= MID_THR_RST;
            thr_reg.min_thr <= MIN_THR_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAX_THR: thr_reg.max_thr <= cfg_wdata;
                REG_MID_THR: thr_reg.mid_thr <= cfg_wdata;
                REG_MIN_THR: thr_reg.min_thr <= cfg_wdata;
                default: ;
            endcase
        end
    end

    jafc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result hand-off
    always_comb begin
        res.valid    = (state_reg == S_OUT);
        res.bad_axis = bad_reg;
        res.axis     = axis_reg;
        res.filtered = acc_reg;
    end

    jafc_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .thr      (thr_reg),
        .out_rdy  (out_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // checks
    `JAFC_ASSERT_NEXT(a_busy_after_xfer, aclk, aresetn, s_xfer, !s_tready,
        "input taken again right after a transfer")
    `JAFC_ASSERT_NOW(a_waddr_range, aclk, aresetn, ram_we, (32'(ram_waddr) < DEPTH),
        "ring write outside the store")
    `JAFC_ASSERT_NOW(a_raddr_range, aclk, aresetn, (state_reg == S_READ),
        (32'(tap_reg) < TAPS) && (32'(ram_raddr) < DEPTH),
        "ring read outside the axis")
    `JAFC_ASSERT_NOW(a_no_bad_write, aclk, aresetn, ram_we, !bad_reg,
        "ring written for an axis outside the store")
    `JAFC_ASSERT_NEXT(a_push_lands, aclk, aresetn, (res.valid && out_rdy), m_tvalid,
        "result push did not reach the output")

endmodule
